// ===== rtl/core/ufst_pkg.sv =====
// Shared types and constants for the union-find spanning-tree block.
// Holds the controller/datapath command and status words and the fixed field widths.
// No dependencies.
package ufst_pkg;

	localparam int NODE_W = 10;
	localparam int CNT_W  = 10;
	localparam int CC_W   = 11;
	localparam int RANK_W = 4;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [RANK_W-1:0] RANK_MAX       = 4'd15;
	localparam logic [CC_W-1:0]   CELL_COUNT_RST = 11'd1024;

	// register index, taken from paddr[2]
	localparam logic REG_CELL_COUNT = 1'b0;

	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef struct packed {
		logic clr_start;  // zero the sweep counter and the edge count
		logic clr_step;   // write one singleton entry, advance the sweep
		logic load_edge;  // capture both nodes of the incoming word
		logic sel_b;      // walk the second node
		logic find_start; // read the start node of a walk
		logic find_step;  // follow one parent link, or take the root
		logic comp_step;  // point one walked entry at the root
		logic link;       // hang one root under the other
		logic rank_up;    // raise the rank of the first root
		logic count_inc;
		logic acc;        // accepted flag for the result word
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic root_hit;
		logic start_root;
		logic comp_last;
		logic clr_last;
		logic full;
		logic same_root;
		logic rank_lt;
		logic rank_gt;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/core/ufst_edge_if.sv =====
// Input channel of the spanning-tree block: one edge word per handshake.
// Depends on ufst_pkg for the node width.
interface ufst_edge_if;
	import ufst_pkg::*;

	logic              valid;
	logic              ready;
	logic              start_new;
	logic [NODE_W-1:0] node_a;
	logic [NODE_W-1:0] node_b;

	modport source (output valid, start_new, node_a, node_b, input ready);
	modport sink (input valid, start_new, node_a, node_b, output ready);
endinterface

// ===== rtl/core/ufst_result_if.sv =====
// Result channel of the spanning-tree block: one verdict word per edge.
// Depends on ufst_pkg for the count width.
interface ufst_result_if;
	import ufst_pkg::*;

	logic             valid;
	logic             ready;
	logic             accepted;
	logic [CNT_W-1:0] tree_size;
	logic             tree_full;

	modport source (output valid, accepted, tree_size, tree_full, input ready);
	modport sink (input valid, accepted, tree_size, tree_full, output ready);
endinterface

// ===== rtl/core/ufst_ctrl.sv =====
// Sequencer of the spanning-tree block: clearing sweep, two root walks with
// compression, the link step and the result hand-off. Depends on ufst_pkg.
module ufst_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_start,
	output logic           in_ready,
	input  ufst_pkg::sts_t sts,
	output ufst_pkg::cmd_t cmd
);
	import ufst_pkg::*;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_CHECK = 9'b000000100,
		S_RD    = 9'b000001000,
		S_FND   = 9'b000010000,
		S_CMP   = 9'b000100000,
		S_LINK  = 9'b001000000,
		S_RANK  = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   side_q, side_d;
	logic   pend_q, pend_d;
	logic   acc_q, acc_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		side_d  = side_q;
		pend_d  = pend_q;
		acc_d   = acc_q;
		cmd     = '0;
		cmd.sel_b = side_q;
		cmd.acc   = acc_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = pend_q ? S_CHECK : S_IDLE;
					pend_d  = 1'b0;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_edge = 1'b1;
					if (in_start) begin
						cmd.clr_start = 1'b1;
						pend_d  = 1'b1;
						state_d = S_CLEAR;
					end else begin
						state_d = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				acc_d  = 1'b0;
				side_d = 1'b0;
				if (sts.full) begin
					state_d = S_OUT;
				end else begin
					cmd.sel_b      = 1'b0;
					cmd.find_start = 1'b1;
					state_d        = S_FND;
				end
			end
			S_RD: begin
				cmd.find_start = 1'b1;
				state_d = S_FND;
			end
			S_FND: begin
				cmd.find_step = 1'b1;
				if (sts.root_hit) begin
					if (!sts.start_root) begin
						state_d = S_CMP;
					end else if (!side_q) begin
						side_d  = 1'b1;
						state_d = S_RD;
					end else begin
						state_d = S_LINK;
					end
				end
			end
			S_CMP: begin
				cmd.comp_step = 1'b1;
				if (sts.comp_last) begin
					if (!side_q) begin
						side_d  = 1'b1;
						state_d = S_RD;
					end else begin
						state_d = S_LINK;
					end
				end
			end
			S_LINK: begin
				if (sts.same_root) begin
					state_d = S_OUT;
				end else begin
					cmd.link = 1'b1;
					if (!sts.rank_lt && !sts.rank_gt) begin
						state_d = S_RANK;
					end else begin
						cmd.count_inc = 1'b1;
						acc_d   = 1'b1;
						state_d = S_OUT;
					end
				end
			end
			S_RANK: begin
				cmd.rank_up   = 1'b1;
				cmd.count_inc = 1'b1;
				acc_d   = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				// hold until the result register is free
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			side_q  <= 1'b0;
			pend_q  <= 1'b0;
			acc_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			side_q  <= side_d;
			pend_q  <= pend_d;
			acc_q   <= acc_d;
		end
	end

endmodule

// ===== rtl/core/ufst_dp.sv =====
// Datapath of the spanning-tree block: the parent/rank table, walk registers,
// edge count, limit logic and the result register. Depends on ufst_pkg.
module ufst_dp #(
	parameter int MAX_CELLS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ufst_pkg::cmd_t              cmd,
	output ufst_pkg::sts_t              sts,
	input  logic [ufst_pkg::CC_W-1:0]   cell_count,
	input  logic [ufst_pkg::NODE_W-1:0] in_node_a,
	input  logic [ufst_pkg::NODE_W-1:0] in_node_b,
	input  logic                        res_ready,
	output logic                        res_valid,
	output logic                        res_accepted,
	output logic [ufst_pkg::CNT_W-1:0]  res_tree_size,
	output logic                        res_tree_full
);
	import ufst_pkg::*;

	localparam int AW = $clog2(MAX_CELLS);
	localparam int EW = RANK_W + AW;
	localparam logic [AW-1:0] LAST_IDX = AW'(MAX_CELLS - 1);

	// entry layout: {rank, parent}
	logic [EW-1:0] uf_mem [MAX_CELLS];

	logic [EW-1:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic          we;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	logic [AW-1:0] a_q, b_q, cur_q, root_a_q, root_b_q, clr_q;
	rank_t         rank_a_q, rank_b_q;
	cnt_t          cnt_q, lim;

	logic [AW-1:0] rd_parent;
	rank_t         rd_rank;
	logic [AW-1:0] start_n;
	logic [AW-1:0] root_sel;
	rank_t         rank_a_inc;

	logic          res_valid_q, res_acc_q, res_full_q;
	cnt_t          res_size_q;

	// reduce a node index into the table by restoring subtraction
	function automatic logic [AW-1:0] wrap_node(input logic [NODE_W-1:0] n);
		logic [31:0] r;
		r = 32'(n);
		for (int i = NODE_W - 1; i >= 0; i--) begin
			if (r >= (32'(MAX_CELLS) << i)) begin
				r = r - (32'(MAX_CELLS) << i);
			end
		end
		return AW'(r);
	endfunction

	// edge limit from the cell count: zero reads as one, clamp to table and count
	always_comb begin
		logic [31:0] n;
		logic [31:0] l;
		n = (cell_count == '0) ? 32'd1 : 32'(cell_count);
		if (n > 32'(MAX_CELLS)) begin
			n = 32'(MAX_CELLS);
		end
		l = n - 32'd1;
		if (l > 32'((1 << CNT_W) - 1)) begin
			l = 32'((1 << CNT_W) - 1);
		end
		lim = CNT_W'(l);
	end

	assign rd_parent  = rd_q[AW-1:0];
	assign rd_rank    = rd_q[EW-1:AW];
	assign start_n    = cmd.sel_b ? b_q : a_q;
	assign root_sel   = cmd.sel_b ? root_b_q : root_a_q;
	assign rank_a_inc = (rank_a_q == RANK_MAX) ? RANK_MAX : rank_a_q + 1'b1;

	assign sts.root_hit   = (rd_parent == cur_q);
	assign sts.start_root = (start_n == cur_q);
	assign sts.comp_last  = (rd_parent == root_sel);
	assign sts.clr_last   = (clr_q == LAST_IDX);
	assign sts.full       = (cnt_q >= lim);
	assign sts.same_root  = (root_a_q == root_b_q);
	assign sts.rank_lt    = (rank_a_q < rank_b_q);
	assign sts.rank_gt    = (rank_a_q > rank_b_q);
	assign sts.out_free   = !res_valid_q || res_ready;

	always_comb begin
		if (cmd.find_start || (cmd.find_step && sts.root_hit)) begin
			rd_addr = start_n;
		end else begin
			rd_addr = rd_parent;
		end
	end

	always_comb begin
		we      = 1'b1;
		wr_addr = clr_q;
		wr_data = {RANK_W'(0), clr_q};
		if (cmd.clr_step) begin
			wr_addr = clr_q;
			wr_data = {RANK_W'(0), clr_q};
		end else if (cmd.comp_step) begin
			wr_addr = cur_q;
			wr_data = {rd_rank, root_sel};
		end else if (cmd.link && sts.rank_lt) begin
			wr_addr = root_a_q;
			wr_data = {rank_a_q, root_b_q};
		end else if (cmd.link) begin
			wr_addr = root_b_q;
			wr_data = {rank_b_q, root_a_q};
		end else if (cmd.rank_up) begin
			wr_addr = root_a_q;
			wr_data = {rank_a_inc, root_a_q};
		end else begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			uf_mem[wr_addr] <= wr_data;
		end
		rd_q <= uf_mem[rd_addr];
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.load_edge) begin
			a_q <= wrap_node(in_node_a);
			b_q <= wrap_node(in_node_b);
		end
		if (cmd.find_start) begin
			cur_q <= start_n;
		end else if (cmd.find_step) begin
			cur_q <= sts.root_hit ? start_n : rd_parent;
		end else if (cmd.comp_step) begin
			cur_q <= rd_parent;
		end
		if (cmd.find_step && sts.root_hit) begin
			if (cmd.sel_b) begin
				root_b_q <= cur_q;
				rank_b_q <= rd_rank;
			end else begin
				root_a_q <= cur_q;
				rank_a_q <= rd_rank;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_start) begin
				clr_q <= '0;
				cnt_q <= '0;
			end else begin
				if (cmd.clr_step) begin
					clr_q <= sts.clr_last ? '0 : clr_q + 1'b1;
				end
				if (cmd.count_inc) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_acc_q  <= cmd.acc;
			res_size_q <= cnt_q;
			res_full_q <= sts.full;
		end
	end

	assign res_valid     = res_valid_q;
	assign res_accepted  = res_acc_q;
	assign res_tree_size = res_size_q;
	assign res_tree_full = res_full_q;

endmodule

// ===== rtl/core/union_find_spanning_tree.sv =====
// Kruskal spanning-tree selector: each edge word names two cells; the block finds
// both roots in a disjoint-set table (union by rank, full path compression) and
// answers with one result word saying whether the edge joined two sets, the tree
// size and whether the tree is full. One edge is in flight at a time: no new edge
// word is taken until the result word of the previous one is loaded. Each edge walks
// both parent chains through the table, pointing every walked entry at its root,
// then links two distinct roots, raising a rank when two roots of equal rank are
// joined; its result word may wait on the receiver. A rejected edge on a full tree
// skips the walks. After reset, and for an edge with start_new set, the table is
// swept back to singletons first, and no edge word is taken during the sweep.
// Depends on ufst_pkg, ufst_ctrl, ufst_dp and the two channel interfaces.
module union_find_spanning_tree #(
	parameter int MAX_CELLS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ufst_edge_if.sink                   edges,
	ufst_result_if.source               results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ufst_pkg::APB_AW-1:0] paddr,
	input  logic [ufst_pkg::APB_DW-1:0] pwdata,
	output logic [ufst_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import ufst_pkg::*;

	cmd_t            cmd;
	sts_t            sts;
	logic [CC_W-1:0] cell_count_q;
	logic            reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_CELL_COUNT);
	assign prdata  = reg_sel ? APB_DW'(cell_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_count_q <= CELL_COUNT_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			cell_count_q <= pwdata[CC_W-1:0];
		end
	end

	ufst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (edges.valid),
		.in_start (edges.start_new),
		.in_ready (edges.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ufst_dp #(
		.MAX_CELLS (MAX_CELLS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cell_count    (cell_count_q),
		.in_node_a     (edges.node_a),
		.in_node_b     (edges.node_b),
		.res_ready     (results.ready),
		.res_valid     (results.valid),
		.res_accepted  (results.accepted),
		.res_tree_size (results.tree_size),
		.res_tree_full (results.tree_full)
	);

	// an accepted edge always leaves a nonzero tree
	a_acc_size: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.accepted |-> results.tree_size != '0)
		else $error("accepted edge with empty tree");

	// never count past the edge limit
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.count_inc |-> !sts.full)
		else $error("edge count advanced on a full tree");

	// link only two distinct roots
	a_link_roots: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.link |-> !sts.same_root)
		else $error("link issued within one set");

	// a rank raise always follows a link of equal ranks
	a_rank_after_link: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rank_up |-> $past(cmd.link))
		else $error("rank raised without a link");

endmodule
